@@ src/tnnto_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the nearest-neighbor tour unit with 2-opt.
// No dependencies; used by the top level.
package tnnto_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NODE_COUNT     = 2'd0,
        CFG_MAX_PASSES     = 2'd1,
        CFG_IMPROVE_MARGIN = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned NODE_OUT_W  = 5;
    localparam int unsigned LEN_W       = 38;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [5:0]  RST_NODE_COUNT = 6'd32;
    localparam logic [15:0] RST_MAX_PASSES = 16'd1000;
    localparam logic [15:0] RST_MARGIN     = 16'd1;

endpackage

@@ src/tnnto_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tnnto_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/tour_nearest_neighbour_two_opt_unit.sv @@
`timescale 1ns / 1ps
// Nearest-neighbor tour builder with first-improvement 2-opt refinement.
// Loading takes one item per cycle; n*n items make one matrix; one matrix at a time.
// After the last item the tour is built, then refined by 2-opt pair by pair (a swap reverses
// its span one entry pair at a time), its length is summed edge by edge, and it is emitted.
// Configuration is accepted only while loading with no input item offered.
// Reset (rst_n low, asynchronous) clears control; memories hold no reset value.
module tour_nearest_neighbour_two_opt_unit #(
    parameter int unsigned MAX_NODES = 32,
    parameter int unsigned DIST_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side: tdata[31:0] = distance
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tnnto_pkg::IN_TDATA_W-1:0]   s_tdata,
    // master side: tdata[4:0] = node_index, [42:5] = tour_length, rest zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tnnto_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [tnnto_pkg::CFG_W-1:0]        cfg_data
);

    localparam int unsigned NW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam int unsigned AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int unsigned LW = $clog2(MAX_NODES * MAX_NODES + 1);
    localparam int unsigned TD = MAX_NODES + 1;
    localparam int unsigned TW = $clog2(TD);
    localparam int unsigned SW = $clog2(MAX_NODES + 2);
    localparam int unsigned XW = DIST_BITS + 2;
    localparam int unsigned LEN_W_C = tnnto_pkg::LEN_W;
    localparam logic [DIST_BITS-1:0] DIST_NONE = '1;

    typedef enum logic [4:0] {
        S_LOAD, S_B_INIT, S_B_SCAN, S_B_PICK, S_B_CLW, S_B_CLC,
        S_R_START, S_R_TRD, S_R_DRD, S_R_DEC, S_R_FLIP, S_R_NEXT,
        S_L_START, S_L_CAP0, S_L_TRD, S_L_TCAP, S_L_DW, S_L_DC,
        S_O_RD, S_O_CAP, S_O_WAIT
    } state_t;

    state_t                 state_reg;
    logic [5:0]             node_count_reg;
    logic [15:0]            max_passes_reg;
    logic [15:0]            margin_reg;
    logic [LW-1:0]          load_cnt_reg;
    logic [MAX_NODES-1:0]   visited_reg;
    logic [SW-1:0]          size_reg;
    logic [CW-1:0]          da_reg;
    logic [CW-1:0]          db_reg;
    logic [CW-1:0]          kcnt_reg;
    logic                   p1_v_reg;
    logic [CW-1:0]          p1_j_reg;
    logic                   found_reg;
    logic [DIST_BITS-1:0]   best_reg;
    logic [CW-1:0]          pick_reg;
    logic                   first_v_reg;
    logic [CW-1:0]          first_reg;
    logic [15:0]            pass_reg;
    logic                   improved_reg;
    logic [TW-1:0]          i_reg;
    logic [TW-1:0]          j_reg;
    logic [TW-1:0]          lo_reg;
    logic [TW-1:0]          hi_reg;
    logic [2:0]             step_reg;
    logic [NW-1:0]          tn_reg [4];
    logic [DIST_BITS-1:0]   dv_reg [4];
    logic [NW-1:0]          vlo_reg;
    logic [NW-1:0]          prev_reg;
    logic [SW-1:0]          k_reg;
    logic [LEN_W_C-1:0]     acc_reg;
    logic                   m_tvalid_reg;
    logic [tnnto_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    logic [CW-1:0]          nact;
    logic [LW-1:0]          total;
    logic [LW-1:0]          cnt_eff;
    logic                   s_acc;
    logic                   cfg_acc;
    logic [AW-1:0]          d_raddr;
    logic [DIST_BITS-1:0]   d_rdata;
    logic                   t_we;
    logic [TW-1:0]          t_waddr;
    logic [NW-1:0]          t_wdata;
    logic [TW-1:0]          t_raddr;
    logic [NW-1:0]          t_rdata;
    logic [CW-1:0]          pick_c;
    logic [XW-1:0]          lhs;
    logic [XW-1:0]          rhs;
    logic [tnnto_pkg::OUT_TDATA_W-1:0] out_word;

    // Clamp node count and derive matrix size
    always_comb
    begin
        if (node_count_reg == 6'd0)
        begin
            nact = CW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            nact = CW'(MAX_NODES);
        end
        else
        begin
            nact = CW'(node_count_reg);
        end
    end

    assign total   = LW'(LW'(nact) * LW'(nact));
    assign cnt_eff = (load_cnt_reg >= total) ? '0 : load_cnt_reg;
    assign s_tready  = (state_reg == S_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == S_LOAD) && !s_tvalid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign d_raddr   = AW'(AW'(da_reg) * AW'(nact) + AW'(db_reg));
    assign pick_c    = found_reg ? pick_reg : first_reg;
    assign lhs = XW'(dv_reg[2]) + XW'(dv_reg[3]) + XW'(margin_reg);
    assign rhs = XW'(dv_reg[0]) + XW'(dv_reg[1]);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Pack one output item; the length rides only on the last one
    always_comb
    begin
        out_word = '0;
        out_word[tnnto_pkg::NODE_OUT_W-1:0] = tnnto_pkg::NODE_OUT_W'(t_rdata);
        if (k_reg + SW'(1) == size_reg)
        begin
            out_word[tnnto_pkg::NODE_OUT_W +: LEN_W_C] = acc_reg;
        end
    end

    // Distance matrix store
    tnnto_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (MAX_NODES * MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (s_acc),
        .waddr (AW'(cnt_eff)),
        .wdata (DIST_BITS'(s_tdata)),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Tour order store
    tnnto_ram #(
        .WIDTH (NW),
        .DEPTH (TD)
    ) u_tour_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Tour memory port control
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        unique case (state_reg)
            S_B_INIT:
            begin
                t_we = 1'b1;
            end
            S_B_PICK:
            begin
                t_we    = 1'b1;
                t_waddr = TW'(size_reg);
                t_wdata = NW'(pick_c);
            end
            S_B_CLC:
            begin
                t_we    = (d_rdata != DIST_NONE);
                t_waddr = TW'(size_reg);
            end
            S_R_TRD:
            begin
                unique case (step_reg)
                    3'd0:    t_raddr = i_reg - TW'(1);
                    3'd1:    t_raddr = i_reg;
                    3'd2:    t_raddr = j_reg;
                    3'd3:    t_raddr = j_reg + TW'(1);
                    default: t_raddr = '0;
                endcase
            end
            S_R_FLIP:
            begin
                unique case (step_reg)
                    3'd0: t_raddr = lo_reg;
                    3'd1: t_raddr = hi_reg;
                    3'd2:
                    begin
                        t_we    = 1'b1;
                        t_waddr = lo_reg;
                        t_wdata = t_rdata;
                    end
                    3'd3:
                    begin
                        t_we    = 1'b1;
                        t_waddr = hi_reg;
                        t_wdata = vlo_reg;
                    end
                    default: t_raddr = '0;
                endcase
            end
            S_L_TRD, S_O_RD:
            begin
                t_raddr = TW'(k_reg);
            end
            default:
            begin
                t_raddr = '0;
            end
        endcase
    end

    // Sequencer: load, build, refine, sum and emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            node_count_reg <= tnnto_pkg::RST_NODE_COUNT;
            max_passes_reg <= tnnto_pkg::RST_MAX_PASSES;
            margin_reg     <= tnnto_pkg::RST_MARGIN;
            load_cnt_reg   <= '0;
            visited_reg    <= '0;
            size_reg       <= '0;
            pass_reg       <= '0;
            p1_v_reg       <= 1'b0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_acc)
            begin
                unique case (tnnto_pkg::cfg_index_t'(cfg_index))
                    tnnto_pkg::CFG_NODE_COUNT:
                    begin
                        node_count_reg <= cfg_data[5:0];
                        load_cnt_reg   <= '0;
                    end
                    tnnto_pkg::CFG_MAX_PASSES:     max_passes_reg <= cfg_data;
                    tnnto_pkg::CFG_IMPROVE_MARGIN: margin_reg     <= cfg_data;
                    tnnto_pkg::CFG_UNUSED:         margin_reg     <= margin_reg;
                endcase
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (cnt_eff + LW'(1) == total)
                        begin
                            load_cnt_reg <= '0;
                            state_reg    <= S_B_INIT;
                        end
                        else
                        begin
                            load_cnt_reg <= cnt_eff + LW'(1);
                        end
                    end
                end

                // Start at node 0
                S_B_INIT:
                begin
                    visited_reg    <= MAX_NODES'(1);
                    size_reg       <= SW'(1);
                    kcnt_reg       <= CW'(1);
                    da_reg         <= '0;
                    db_reg         <= '0;
                    found_reg      <= 1'b0;
                    first_v_reg    <= 1'b0;
                    p1_v_reg       <= 1'b0;
                    state_reg      <= (nact == CW'(1)) ? S_L_START : S_B_SCAN;
                end

                // Stream one row and track nearest unvisited neighbor
                S_B_SCAN:
                begin
                    if (p1_v_reg)
                    begin
                        if (!visited_reg[p1_j_reg[NW-1:0]])
                        begin
                            if (!first_v_reg)
                            begin
                                first_v_reg <= 1'b1;
                                first_reg   <= p1_j_reg;
                            end
                            if (d_rdata != DIST_NONE && (!found_reg || d_rdata < best_reg))
                            begin
                                found_reg <= 1'b1;
                                best_reg  <= d_rdata;
                                pick_reg  <= p1_j_reg;
                            end
                        end
                    end
                    if (db_reg < nact)
                    begin
                        p1_v_reg <= 1'b1;
                        p1_j_reg <= db_reg;
                        db_reg   <= db_reg + CW'(1);
                    end
                    else
                    begin
                        p1_v_reg <= 1'b0;
                        if (!p1_v_reg)
                        begin
                            state_reg <= S_B_PICK;
                        end
                    end
                end

                // Append the chosen node
                S_B_PICK:
                begin
                    visited_reg[pick_c[NW-1:0]] <= 1'b1;
                    size_reg    <= size_reg + SW'(1);
                    kcnt_reg    <= kcnt_reg + CW'(1);
                    da_reg      <= pick_c;
                    db_reg      <= '0;
                    found_reg   <= 1'b0;
                    first_v_reg <= 1'b0;
                    state_reg   <= (kcnt_reg == nact - CW'(1)) ? S_B_CLW : S_B_SCAN;
                end

                S_B_CLW:
                begin
                    state_reg <= S_B_CLC;
                end

                // Close the tour when the return edge is reachable
                S_B_CLC:
                begin
                    if (d_rdata != DIST_NONE)
                    begin
                        size_reg <= size_reg + SW'(1);
                    end
                    state_reg <= S_R_START;
                end

                S_R_START:
                begin
                    pass_reg <= '0;
                    if (size_reg <= SW'(3) || max_passes_reg == 16'd0)
                    begin
                        state_reg <= S_L_START;
                    end
                    else
                    begin
                        pass_reg     <= 16'd1;
                        improved_reg <= 1'b0;
                        i_reg        <= TW'(1);
                        j_reg        <= TW'(2);
                        step_reg     <= '0;
                        state_reg    <= S_R_TRD;
                    end
                end

                // Fetch the four tour nodes of the pair
                S_R_TRD:
                begin
                    if (step_reg != 3'd0)
                    begin
                        tn_reg[step_reg[1:0] - 2'd1] <= t_rdata;
                    end
                    if (step_reg == 3'd4)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_R_DRD;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end

                // Fetch current and proposed edges
                S_R_DRD:
                begin
                    unique case (step_reg)
                        3'd0:
                        begin
                            da_reg <= CW'(tn_reg[0]);
                            db_reg <= CW'(tn_reg[1]);
                        end
                        3'd1:
                        begin
                            da_reg <= CW'(tn_reg[2]);
                            db_reg <= CW'(tn_reg[3]);
                        end
                        3'd2:
                        begin
                            da_reg <= CW'(tn_reg[0]);
                            db_reg <= CW'(tn_reg[2]);
                        end
                        3'd3:
                        begin
                            da_reg <= CW'(tn_reg[1]);
                            db_reg <= CW'(tn_reg[3]);
                        end
                        default:
                        begin
                            da_reg <= da_reg;
                        end
                    endcase
                    if (step_reg >= 3'd2)
                    begin
                        dv_reg[2'(step_reg - 3'd2)] <= d_rdata;
                    end
                    if (step_reg == 3'd5)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_R_DEC;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end

                // Decide on the swap
                S_R_DEC:
                begin
                    step_reg <= '0;
                    if (dv_reg[2] == DIST_NONE || dv_reg[3] == DIST_NONE)
                    begin
                        state_reg <= S_R_NEXT;
                    end
                    else if (dv_reg[0] == DIST_NONE || dv_reg[1] == DIST_NONE
                             || lhs < rhs)
                    begin
                        improved_reg <= 1'b1;
                        lo_reg       <= i_reg;
                        hi_reg       <= j_reg;
                        state_reg    <= S_R_FLIP;
                    end
                    else
                    begin
                        state_reg <= S_R_NEXT;
                    end
                end

                // Reverse the span one entry pair at a time
                S_R_FLIP:
                begin
                    if (step_reg == 3'd1)
                    begin
                        vlo_reg <= t_rdata;
                    end
                    if (step_reg == 3'd3)
                    begin
                        lo_reg   <= lo_reg + TW'(1);
                        hi_reg   <= hi_reg - TW'(1);
                        step_reg <= '0;
                        if ((SW+1)'(lo_reg) + (SW+1)'(2) >= (SW+1)'(hi_reg))
                        begin
                            state_reg <= S_R_NEXT;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end

                // Advance to the next pair or pass
                S_R_NEXT:
                begin
                    step_reg <= '0;
                    if ((SW+1)'(j_reg) + (SW+1)'(2) < (SW+1)'(size_reg))
                    begin
                        j_reg     <= j_reg + TW'(1);
                        state_reg <= S_R_TRD;
                    end
                    else if ((SW+1)'(i_reg) + (SW+1)'(3) < (SW+1)'(size_reg))
                    begin
                        i_reg     <= i_reg + TW'(1);
                        j_reg     <= i_reg + TW'(2);
                        state_reg <= S_R_TRD;
                    end
                    else if (improved_reg && pass_reg < max_passes_reg)
                    begin
                        pass_reg     <= pass_reg + 16'd1;
                        improved_reg <= 1'b0;
                        i_reg        <= TW'(1);
                        j_reg        <= TW'(2);
                        state_reg    <= S_R_TRD;
                    end
                    else
                    begin
                        state_reg <= S_L_START;
                    end
                end

                S_L_START:
                begin
                    k_reg     <= '0;
                    state_reg <= S_L_CAP0;
                end

                // Sum reachable edges along the tour
                S_L_CAP0:
                begin
                    prev_reg <= t_rdata;
                    acc_reg  <= '0;
                    if (size_reg == SW'(1))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_O_RD;
                    end
                    else
                    begin
                        k_reg     <= SW'(1);
                        state_reg <= S_L_TRD;
                    end
                end

                S_L_TRD:
                begin
                    state_reg <= S_L_TCAP;
                end

                S_L_TCAP:
                begin
                    da_reg    <= CW'(prev_reg);
                    db_reg    <= CW'(t_rdata);
                    prev_reg  <= t_rdata;
                    state_reg <= S_L_DW;
                end

                S_L_DW:
                begin
                    state_reg <= S_L_DC;
                end

                S_L_DC:
                begin
                    if (d_rdata != DIST_NONE)
                    begin
                        acc_reg <= acc_reg + LEN_W_C'(d_rdata);
                    end
                    if (k_reg + SW'(1) == size_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_O_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + SW'(1);
                        state_reg <= S_L_TRD;
                    end
                end

                S_O_RD:
                begin
                    state_reg <= S_O_CAP;
                end

                // Present one tour item
                S_O_CAP:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tlast_reg  <= (k_reg + SW'(1) == size_reg);
                    m_tdata_reg  <= out_word;
                    state_reg    <= S_O_WAIT;
                end

                S_O_WAIT:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        if (m_tlast_reg)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + SW'(1);
                            state_reg <= S_O_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule
